// File: rtl/core/srwin_pkg.sv
// ----------------------------------------------------------------------------
// srwin_pkg
// Shared constants and types of the selective-repeat receive window.
// ----------------------------------------------------------------------------
package srwin_pkg;

    // Field widths of a frame request and of a result.
    localparam int SEQ_W = 8;
    localparam int TAG_W = 32;
    localparam int LEN_W = 11;

    // Sequence space and the length clamp follow from the fixed field widths.
    localparam int SEQ_SPACE       = 256;
    localparam int MAX_FRAME_BYTES = 2047;

    // Default number of receive slots.
    localparam int WINDOW_DEF = 8;

    // Stream bus packing.
    localparam int IN_PAYLOAD_W  = SEQ_W + TAG_W + LEN_W;
    localparam int IN_TDATA_W    = ((IN_PAYLOAD_W + 7) / 8) * 8;
    localparam int OUT_PAYLOAD_W = TAG_W + LEN_W + SEQ_W;
    localparam int OUT_TDATA_W   = ((OUT_PAYLOAD_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W   = 2;

    // Bit positions of the input fields in s_axis_tdata.
    localparam int IN_SEQ_LSB = 0;
    localparam int IN_TAG_LSB = SEQ_W;
    localparam int IN_LEN_LSB = SEQ_W + TAG_W;

    // Bit positions of the result flags in m_axis_tuser.
    localparam int TUSER_DELIVERED = 0;
    localparam int TUSER_ACCEPTED  = 1;

    // One buffered frame as it sits in the slot memory.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
    } entry_t;

    // Result payload, lowest field in the lowest bits.
    typedef struct packed {
        logic [SEQ_W-1:0] next_expected;
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
    } out_payload_t;

endpackage

// File: rtl/core/srwin_ram.sv
// ----------------------------------------------------------------------------
// srwin_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module srwin_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/selective_repeat_reorder_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_reorder_window
// Receive side of a selective-repeat window that reorders arriving frames.
// ----------------------------------------------------------------------------
// Each request on the s_axis channel is one arriving frame. A frame whose
// sequence number lies within WINDOW numbers at or after next_expected is
// accepted and buffered in its slot, unless that slot already holds a frame,
// in which case the new copy is dropped. Frames outside the window change
// nothing. After every frame the block releases on m_axis, in order, each
// frame that is now contiguous from next_expected, one result per frame, and
// advances next_expected past it. When nothing is released, a single status
// result is given instead. m_axis_tlast marks the final result of a frame.
//
// Timing: s_axis_tready is high only while no frame is in work. A frame that
// releases nothing passes through ST_SCAN alone; each released frame costs a
// read of the slot RAM in ST_SCAN and a load of its result in ST_EMIT.
// m_axis_tvalid rises once the result register is loaded, in ST_SCAN for a
// status result and in ST_EMIT for a released frame; ST_SCAN waits while a
// previous result is still stalled.
//
// Reset (aresetn low at a clock edge) empties the window and clears
// next_expected to zero; the slot RAM needs no clearing, as a slot is read
// only once its occupied bit is set. When the receiver holds m_axis_tready
// low, the result register keeps its request and the release scan waits.
// ----------------------------------------------------------------------------
module selective_repeat_reorder_window #(
    parameter int WINDOW = srwin_pkg::WINDOW_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // sequence_number[7:0], frame_tag[39:8], frame_length[50:40], zero fill
    input  logic [srwin_pkg::IN_TDATA_W-1:0]     s_axis_tdata,

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // delivered_tag[31:0], delivered_length[42:32], next_expected_out[50:43],
    // zero fill
    output logic [srwin_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // delivered[0], accepted[1]
    output logic [srwin_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    output logic                                 m_axis_tlast
);

    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int ENTRY_W = $bits(srwin_pkg::entry_t);
    localparam int PAD_W   = srwin_pkg::OUT_TDATA_W - srwin_pkg::OUT_PAYLOAD_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                            state_reg, state_next;
    logic                              acc_reg, acc_next;
    logic [SLOT_W-1:0]                 head_reg, head_next;
    logic [srwin_pkg::SEQ_W-1:0]       next_exp_reg, next_exp_next;
    logic [WINDOW-1:0]                 present_reg, present_next;
    logic                              last_pend_reg, last_pend_next;

    logic                              out_valid_reg, out_valid_next;
    srwin_pkg::out_payload_t           out_data_reg, out_data_next;
    logic [srwin_pkg::OUT_TUSER_W-1:0] out_user_reg, out_user_next;
    logic                              out_last_reg, out_last_next;

    // Input fields.
    logic [srwin_pkg::SEQ_W-1:0]       in_seq;
    logic [srwin_pkg::TAG_W-1:0]       in_tag;
    logic [srwin_pkg::LEN_W-1:0]       in_len;
    logic [srwin_pkg::LEN_W-1:0]       in_len_sat;
    logic [srwin_pkg::SEQ_W-1:0]       in_dist;
    logic                              in_acc;
    logic [SLOT_W:0]                   slot_sum;
    logic [SLOT_W-1:0]                 in_slot;

    logic [SLOT_W-1:0]                 head_inc;
    logic                              out_free;

    logic                              ram_we;
    srwin_pkg::entry_t                 ram_wdata;
    srwin_pkg::entry_t                 ram_rdata;
    logic [ENTRY_W-1:0]                ram_rdata_raw;

    assign in_seq = s_axis_tdata[srwin_pkg::IN_SEQ_LSB +: srwin_pkg::SEQ_W];
    assign in_tag = s_axis_tdata[srwin_pkg::IN_TAG_LSB +: srwin_pkg::TAG_W];
    assign in_len = s_axis_tdata[srwin_pkg::IN_LEN_LSB +: srwin_pkg::LEN_W];

    assign in_len_sat = (in_len > srwin_pkg::LEN_W'(srwin_pkg::MAX_FRAME_BYTES))
                      ? srwin_pkg::LEN_W'(srwin_pkg::MAX_FRAME_BYTES) : in_len;

    // The sequence space spans the whole field, so the distance wraps for free.
    assign in_dist = in_seq - next_exp_reg;
    assign in_acc  = in_dist < srwin_pkg::SEQ_W'(WINDOW);

    // The head slot tracks next_expected mod WINDOW; an in-window frame sits
    // fewer than WINDOW slots past it, so one conditional subtract wraps it.
    // When the window straddles the end of the sequence space, an in-window
    // frame past the wrap has a number below WINDOW, which is its own slot.
    assign slot_sum = {1'b0, head_reg} + {1'b0, in_dist[SLOT_W-1:0]};
    assign in_slot  = (in_seq < next_exp_reg) ? in_seq[SLOT_W-1:0]
                    : (slot_sum >= (SLOT_W + 1)'(WINDOW))
                    ? SLOT_W'(slot_sum - (SLOT_W + 1)'(WINDOW))
                    : slot_sum[SLOT_W-1:0];

    // next_expected wrapping back to zero restarts the head at slot zero.
    assign head_inc = (next_exp_reg == '1 || head_reg == SLOT_W'(WINDOW - 1))
                    ? '0 : head_reg + 1'b1;

    assign out_free = !out_valid_reg || m_axis_tready;

    assign ram_wdata = '{len: in_len_sat, tag: in_tag};
    assign ram_rdata = srwin_pkg::entry_t'(ram_rdata_raw);

    srwin_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (in_slot),
        .wr_data (ram_wdata),
        .rd_addr (head_reg),
        .rd_data (ram_rdata_raw)
    );

    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        head_next      = head_reg;
        next_exp_next  = next_exp_reg;
        present_next   = present_reg;
        last_pend_next = last_pend_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;

        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    acc_next = in_acc;
                    // A duplicate leaves the buffered copy in place.
                    if (in_acc && !present_reg[in_slot]) begin
                        ram_we                = 1'b1;
                        present_next[in_slot] = 1'b1;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    if (acc_reg && present_reg[head_reg]) begin
                        // Release the head slot; the RAM read is under way.
                        present_next[head_reg] = 1'b0;
                        head_next              = head_inc;
                        next_exp_next          = next_exp_reg + 1'b1;
                        last_pend_next         = !present_reg[head_inc] ||
                                                 (head_inc == head_reg);
                        state_next             = ST_EMIT;
                    end else begin
                        // Nothing to release: one status result.
                        out_valid_next = 1'b1;
                        out_data_next  = '{next_expected: next_exp_reg,
                                           len: '0, tag: '0};
                        out_user_next  = '0;
                        out_user_next[srwin_pkg::TUSER_ACCEPTED] = acc_reg;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                // The result register was freed when the read was issued.
                out_valid_next = 1'b1;
                out_data_next  = '{next_expected: next_exp_reg,
                                   len: ram_rdata.len, tag: ram_rdata.tag};
                out_user_next  = '0;
                out_user_next[srwin_pkg::TUSER_DELIVERED] = 1'b1;
                out_user_next[srwin_pkg::TUSER_ACCEPTED]  = 1'b1;
                out_last_next  = last_pend_reg;
                state_next     = last_pend_reg ? ST_IDLE : ST_SCAN;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            acc_reg       <= 1'b0;
            head_reg      <= '0;
            next_exp_reg  <= '0;
            present_reg   <= '0;
            last_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            head_reg      <= head_next;
            next_exp_reg  <= next_exp_next;
            present_reg   <= present_next;
            last_pend_reg <= last_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_data_reg};
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: rtl/core/srwin_checker.sv
// ----------------------------------------------------------------------------
// srwin_checker
// Port-level assertions for the selective-repeat receive window.
// ----------------------------------------------------------------------------
module srwin_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [srwin_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input logic [srwin_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    input logic                                 m_axis_tlast
);

    localparam int FRAME_W = srwin_pkg::TAG_W + srwin_pkg::LEN_W;

    // A status result is always the only and final result of its frame.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[srwin_pkg::TUSER_DELIVERED] |-> m_axis_tlast)
        else $error("status result without tlast");

    // A status result carries no frame tag or length.
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[srwin_pkg::TUSER_DELIVERED]
        |-> m_axis_tdata[FRAME_W-1:0] == '0)
        else $error("status result with frame payload");

    // Only a frame inside the window can release anything.
    a_deliver_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[srwin_pkg::TUSER_DELIVERED]
        |-> m_axis_tuser[srwin_pkg::TUSER_ACCEPTED])
        else $error("delivery from a frame outside the window");

    // A stalled result request holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

endmodule

bind selective_repeat_reorder_window srwin_checker u_srwin_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
